[hdl/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, register codes and channel arithmetic for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

   localparam int unsigned MaxWidthDefault  = 1024;
   localparam int unsigned MaxHeightDefault = 4096;

   localparam int unsigned WidthRegW  = 11;
   localparam int unsigned HeightRegW = 13;
   localparam int unsigned CsrDataW   = 13;
   localparam int unsigned PixelW     = 32;

   localparam int unsigned WidthReset  = 800;
   localparam int unsigned HeightReset = 600;

   localparam int unsigned SumW     = 12;
   localparam int unsigned ProdW    = 25;
   localparam int unsigned Div9Mul  = 7282;
   localparam int unsigned Div9Sh   = 16;
   localparam logic [7:0]  AlphaOut = 8'hFF;

   typedef enum logic [0:0] {
      RegFrameWidth  = 1'b0,
      RegFrameHeight = 1'b1
   } csr_reg_type;

   typedef logic [23:0] rgb_type;

   // rows: [0] two above, [1] above, [2] current
   typedef rgb_type [2:0] col_type;

   typedef struct packed {
      logic    keep;
      logic    col0;
      logic    load;
      logic    row_ge1;
      logic    row_ge2;
      logic    emit;
      logic    frame_end;
      rgb_type pix;
   } item_type;

   function automatic logic [7:0] chan_avg(input col_type a, input col_type b,
                                           input col_type c, input int unsigned sh);
      logic [SumW-1:0]  s;
      logic [ProdW-1:0] p;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         s = s + SumW'(a[i][sh +: 8]) + SumW'(b[i][sh +: 8]) + SumW'(c[i][sh +: 8]);
      end
      p = ProdW'(s) * ProdW'(Div9Mul);
      return p[Div9Sh +: 8];
   endfunction

endpackage

[hdl/bblur_if.sv]
// ----------------------------------------------------------------------------
// bblur request and response channels
// Valid/ready channels carrying input pixels and blurred result items.
// ----------------------------------------------------------------------------
interface bblur_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [bblur_pkg::PixelW-1:0]   pixel_in;

   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface bblur_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bblur_pkg::PixelW-1:0]   pixel_out;
   logic                           frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[hdl/bblur_ram.sv]
// ----------------------------------------------------------------------------
// bblur_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bblur_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bblur_ctrl.sv]
// ----------------------------------------------------------------------------
// bblur_ctrl
// Frame size registers and input/output raster position counters.
// ----------------------------------------------------------------------------
module bblur_ctrl #(
   parameter int unsigned MAX_WIDTH  = bblur_pkg::MaxWidthDefault,
   parameter int unsigned MAX_HEIGHT = bblur_pkg::MaxHeightDefault,
   localparam int unsigned AW = $clog2(MAX_WIDTH),
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 2)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  bblur_pkg::csr_reg_type            csr_index,
   input  logic [bblur_pkg::CsrDataW-1:0]    csr_wdata,
   input  logic                              accept,
   input  logic                              op,
   input  logic [bblur_pkg::PixelW-1:0]      pixel_in,
   output bblur_pkg::item_type               item,
   output logic [AW-1:0]                     rd_addr,
   output logic                              cfg_clear
);

   localparam int unsigned WCap = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
   localparam int unsigned HCap = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
   localparam logic [bblur_pkg::WidthRegW-1:0] WidthMax =
      bblur_pkg::WidthRegW'(WCap);
   localparam logic [bblur_pkg::HeightRegW-1:0] HeightMax =
      bblur_pkg::HeightRegW'(HCap);
   localparam logic [bblur_pkg::WidthRegW-1:0] WidthRst =
      bblur_pkg::WidthRegW'((bblur_pkg::WidthReset > WCap) ? WCap : bblur_pkg::WidthReset);
   localparam logic [bblur_pkg::HeightRegW-1:0] HeightRst =
      bblur_pkg::HeightRegW'((bblur_pkg::HeightReset > HCap) ? HCap : bblur_pkg::HeightReset);

   logic [bblur_pkg::WidthRegW-1:0]  width_ff, width_in, wval;
   logic [bblur_pkg::HeightRegW-1:0] height_ff, height_in, hval;
   logic [AW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic [31:0] w32, h32;
   logic        real_pix, last_col, out_last_col;

   assign w32 = 32'(width_ff);
   assign h32 = 32'(height_ff);

   assign real_pix     = 32'(in_row_ff) < h32;
   assign last_col     = (32'(in_col_ff) + 32'd1) >= w32;
   assign out_last_col = (32'(out_col_ff) + 32'd1) >= w32;

   always_comb begin
      item.keep      = !(op && real_pix);
      item.col0      = (in_col_ff == '0);
      item.row_ge1   = (in_row_ff != '0);
      item.row_ge2   = 32'(in_row_ff) >= 32'd2;
      item.load      = item.col0 ? (32'(in_row_ff) <= h32) : 1'b1;
      item.emit      = item.col0 ? item.row_ge2 : item.row_ge1;
      item.frame_end = (32'(out_row_ff) + 32'd1 >= h32) && out_last_col;
      item.pix       = real_pix ? pixel_in[31:8] : '0;
   end

   assign rd_addr   = in_col_ff;
   assign cfg_clear = csr_wr_en;

   assign wval = csr_wdata[bblur_pkg::WidthRegW-1:0];
   assign hval = csr_wdata[bblur_pkg::HeightRegW-1:0];

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bblur_pkg::RegFrameWidth: begin
               if (wval == '0) begin
                  width_in = bblur_pkg::WidthRegW'(1);
               end else if (wval > WidthMax) begin
                  width_in = WidthMax;
               end else begin
                  width_in = wval;
               end
            end
            bblur_pkg::RegFrameHeight: begin
               if (hval == '0) begin
                  height_in = bblur_pkg::HeightRegW'(1);
               end else if (hval > HeightMax) begin
                  height_in = HeightMax;
               end else begin
                  height_in = hval;
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && item.keep) begin
         if (last_col) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
         if (item.emit) begin
            if (item.frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WidthRst;
         height_ff  <= HeightRst;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   a_in_col_bound: assert property (@(posedge clock) disable iff (reset)
      32'(in_col_ff) < w32)
      else $error("input column beyond frame width");

   a_in_row_bound: assert property (@(posedge clock) disable iff (reset)
      32'(in_row_ff) <= h32 + 32'd1)
      else $error("input row beyond drain row");

   a_out_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(out_row_ff) < h32) && (32'(out_col_ff) < w32))
      else $error("output position outside frame");

endmodule

[hdl/bblur_filter.sv]
// ----------------------------------------------------------------------------
// bblur_filter
// Window stage with line store access, 3x3 sum and divide, result register.
// ----------------------------------------------------------------------------
module bblur_filter #(
   parameter int unsigned MAX_WIDTH = bblur_pkg::MaxWidthDefault,
   localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  bblur_pkg::item_type            item,
   input  logic [AW-1:0]                  addr,
   input  logic                           cfg_clear,
   output logic                           in_ready,
   output logic                           ram_rd_en,
   input  logic [47:0]                    ram_rd_data,
   output logic                           ram_wr_en,
   output logic [AW-1:0]                  ram_wr_addr,
   output logic [47:0]                    ram_wr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bblur_pkg::PixelW-1:0]   rsp_pixel_out,
   output logic                           rsp_frame_end
);

   logic                  a_valid_ff, a_valid_in;
   bblur_pkg::item_type   a_item_ff;
   logic [AW-1:0]         a_addr_ff;
   logic                  a_fwd_ff;
   logic [47:0]           a_fwd_data_ff;

   bblur_pkg::col_type    mid_ff, mid_in, right_ff, right_in;
   logic                  out_valid_ff, out_valid_in;
   logic [bblur_pkg::PixelW-1:0] out_pixel_ff;
   logic                  out_end_ff;

   logic                  a_done, a_load;
   logic [47:0]           line;
   bblur_pkg::col_type    new_col, third;
   logic [7:0]            r_avg, g_avg, b_avg;

   assign a_done = a_valid_ff && (!a_item_ff.emit || !out_valid_ff || rsp_ready);
   assign in_ready = !a_valid_ff || a_done;
   assign a_load = accept && item.keep;
   assign ram_rd_en = a_load && item.load;

   assign line = a_fwd_ff ? a_fwd_data_ff : ram_rd_data;

   always_comb begin
      new_col[0] = a_item_ff.row_ge2 ? line[47:24] : '0;
      new_col[1] = a_item_ff.row_ge1 ? line[23:0] : '0;
      new_col[2] = a_item_ff.pix;
      third      = a_item_ff.col0 ? '0 : new_col;
   end

   assign r_avg = bblur_pkg::chan_avg(mid_ff, right_ff, third, 16);
   assign g_avg = bblur_pkg::chan_avg(mid_ff, right_ff, third, 8);
   assign b_avg = bblur_pkg::chan_avg(mid_ff, right_ff, third, 0);

   assign ram_wr_en   = a_done && a_item_ff.load;
   assign ram_wr_addr = a_addr_ff;
   assign ram_wr_data = {line[23:0], a_item_ff.pix};

   always_comb begin
      mid_in   = mid_ff;
      right_in = right_ff;
      if (cfg_clear) begin
         mid_in   = '0;
         right_in = '0;
      end else if (a_done) begin
         if (a_item_ff.emit && a_item_ff.frame_end) begin
            mid_in   = '0;
            right_in = '0;
         end else if (a_item_ff.col0 && a_item_ff.load) begin
            mid_in   = '0;
            right_in = new_col;
         end else begin
            mid_in   = right_ff;
            right_in = third;
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_load) begin
         a_valid_in = 1'b1;
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (a_done && a_item_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         mid_ff       <= '0;
         right_ff     <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         mid_ff       <= mid_in;
         right_ff     <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_item_ff     <= item;
         a_addr_ff     <= addr;
         a_fwd_ff      <= ram_wr_en && (a_addr_ff == addr);
         a_fwd_data_ff <= ram_wr_data;
      end
      if (a_done && a_item_ff.emit) begin
         out_pixel_ff <= {r_avg, g_avg, b_avg, bblur_pkg::AlphaOut};
         out_end_ff   <= a_item_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_frame_end = out_end_ff;

   a_wr_from_stage: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> a_valid_ff && a_item_ff.load)
      else $error("line store written without a loading item in the window stage");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (a_load && ram_wr_en && (a_addr_ff == addr)) |=> a_fwd_ff)
      else $error("same-column write not forwarded to next item");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> out_valid_ff && $stable(out_pixel_ff))
      else $error("pending result lost while receiver stalls");

endmodule

[hdl/box_blur_3x3_rgb_top.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// Streaming 3x3 RGB box blur with two line stores and zero-padded borders.
//
// Items arrive on req (op, pixel_in) in raster order and results leave on
// rsp (pixel_out, frame_end) under valid/ready; an item moves when both are
// high. Frame size is set on the csr write port; the user must do so only
// while the block is idle, as the block does not enforce it. A write
// restarts the frame. A result lags its pixel by one row plus one pixel,
// so op=1 flush items drain the last row after the final pixel; frame_end
// marks the last result of the frame. Throughput: one item per cycle
// while rsp does not stall. An accepted item is registered in the window
// stage together with the registered read of the line store RAM, and its
// result is then registered in the output register that drives rsp.valid.
// Reset clears positions, window and result valid flag and loads 800 x 600
// (capped by the maximum size); line store contents stay unknown and are
// masked by row position. When rsp stalls, the result is held and one more
// item may enter the window stage before req.ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
   parameter int unsigned MAX_WIDTH  = bblur_pkg::MaxWidthDefault,
   parameter int unsigned MAX_HEIGHT = bblur_pkg::MaxHeightDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   bblur_req_if.sink                       req,
   bblur_rsp_if.source                     rsp,
   input  logic                            csr_wr_en,
   input  bblur_pkg::csr_reg_type          csr_index,
   input  logic [bblur_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);

   bblur_pkg::item_type item;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                cfg_clear, in_ready, accept;
   logic                rd_en, wr_en;
   logic [47:0]         rd_data, wr_data;

   assign accept    = req.valid && in_ready;
   assign req.ready = in_ready;

   bblur_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .op        (req.op),
      .pixel_in  (req.pixel_in),
      .item      (item),
      .rd_addr   (rd_addr),
      .cfg_clear (cfg_clear)
   );

   bblur_ram #(
      .WIDTH (48),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bblur_filter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_filter (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (item),
      .addr          (rd_addr),
      .cfg_clear     (cfg_clear),
      .in_ready      (in_ready),
      .ram_rd_en     (rd_en),
      .ram_rd_data   (rd_data),
      .ram_wr_en     (wr_en),
      .ram_wr_addr   (wr_addr),
      .ram_wr_data   (wr_data),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_pixel_out (rsp.pixel_out),
      .rsp_frame_end (rsp.frame_end)
   );

endmodule

[dv/box_blur_3x3_rgb_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top_tb
// Self-checking bench for the streaming 3x3 box blur. A scoreboard class
// keeps its own line stores, window and raster positions. It predicts every
// blurred pixel and frame_end mark from the accepted items and checks the
// results in order. The stimulus has a short directed part: extreme pixels,
// early flushes, a pixel after the last, and zero and oversized frame sizes.
// A random part follows with many small frames, cut frames, random sizes and
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top_tb;

   localparam int unsigned CycleLimit = 1000000;

   typedef struct packed {
      logic [bblur_pkg::PixelW-1:0] pixel;
      logic                         frame_end;
   } blur_result_type;

   class blur_scoreboard;
      int unsigned       width;
      int unsigned       height;
      bblur_pkg::rgb_type line_above [bblur_pkg::MaxWidthDefault];
      bblur_pkg::rgb_type line_two_above [bblur_pkg::MaxWidthDefault];
      bblur_pkg::rgb_type win [3][3];
      int unsigned       in_col;
      int unsigned       in_row;
      int unsigned       out_col;
      int unsigned       out_row;
      blur_result_type   blurred_q [$];
      int unsigned       errors;

      function new();
         foreach (line_above[i]) begin
            line_above[i] = '0;
            line_two_above[i] = '0;
         end
         width = clip_size(bblur_pkg::WidthReset, bblur_pkg::MaxWidthDefault);
         height = clip_size(bblur_pkg::HeightReset, bblur_pkg::MaxHeightDefault);
         errors = 0;
         restart_frame();
      endfunction

      function int unsigned clip_size(int unsigned v, int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function void restart_frame();
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         foreach (win[c, r]) win[c][r] = '0;
      endfunction

      function void write_reg(bblur_pkg::csr_reg_type idx,
                              logic [bblur_pkg::CsrDataW-1:0] value);
         case (idx)
            bblur_pkg::RegFrameWidth:
               width = clip_size(value[bblur_pkg::WidthRegW-1:0],
                                 bblur_pkg::MaxWidthDefault);
            bblur_pkg::RegFrameHeight:
               height = clip_size(value[bblur_pkg::HeightRegW-1:0],
                                  bblur_pkg::MaxHeightDefault);
            default: ;
         endcase
         restart_frame();
      endfunction

      function void shift_column(bblur_pkg::rgb_type top, bblur_pkg::rgb_type mid,
                                 bblur_pkg::rgb_type bot);
         for (int r = 0; r < 3; r++) begin
            win[0][r] = win[1][r];
            win[1][r] = win[2][r];
         end
         win[2][0] = top;
         win[2][1] = mid;
         win[2][2] = bot;
      endfunction

      function logic [bblur_pkg::PixelW-1:0] box_average();
         int unsigned rs;
         int unsigned gs;
         int unsigned bs;
         rs = 0;
         gs = 0;
         bs = 0;
         foreach (win[c, r]) begin
            rs += win[c][r][23:16];
            gs += win[c][r][15:8];
            bs += win[c][r][7:0];
         end
         return {8'(rs / 9), 8'(gs / 9), 8'(bs / 9), bblur_pkg::AlphaOut};
      endfunction

      function void load_column(int unsigned c, bblur_pkg::rgb_type pix, bit in_frame);
         bblur_pkg::rgb_type top;
         bblur_pkg::rgb_type mid;
         bblur_pkg::rgb_type bot;
         top = (in_row >= 2) ? line_two_above[c] : '0;
         mid = (in_row >= 1) ? line_above[c] : '0;
         bot = in_frame ? pix : '0;
         line_two_above[c] = line_above[c];
         line_above[c] = bot;
         shift_column(top, mid, bot);
      endfunction

      // returns 0 when the block ignores the item
      function bit note_item(bit op, logic [bblur_pkg::PixelW-1:0] pix);
         bit                           in_frame;
         bit                           emit;
         logic [bblur_pkg::PixelW-1:0] blurred;
         bit                           last_out;
         in_frame = in_row < height;
         emit = 0;
         blurred = '0;
         if (op && in_frame) return 0;
         if (in_col == 0) begin
            if (in_row >= 2) begin
               shift_column('0, '0, '0);
               blurred = box_average();
               emit = 1;
            end
            if (in_row <= height) begin
               foreach (win[c, r]) win[c][r] = '0;
               load_column(0, pix[31:8], in_frame);
            end
         end else begin
            load_column(in_col, pix[31:8], in_frame);
            if (in_row >= 1) begin
               blurred = box_average();
               emit = 1;
            end
         end
         in_col++;
         if (in_col >= width) begin
            in_col = 0;
            in_row++;
         end
         if (!emit) return 1;
         last_out = (out_row >= height - 1) && (out_col >= width - 1);
         blurred_q.push_back('{pixel: blurred, frame_end: last_out});
         if (last_out) begin
            restart_frame();
         end else begin
            out_col++;
            if (out_col >= width) begin
               out_col = 0;
               out_row++;
            end
         end
         return 1;
      endfunction

      function void check_result(logic [bblur_pkg::PixelW-1:0] pix, logic fe);
         blur_result_type want;
         if (blurred_q.size() == 0) begin
            $display("%0t: unexpected result pixel_out=%h frame_end=%b", $time, pix, fe);
            errors++;
            return;
         end
         want = blurred_q.pop_front();
         if (pix !== want.pixel) begin
            $display("%0t: pixel_out mismatch expected=%h actual=%h", $time, want.pixel, pix);
            errors++;
         end
         if (fe !== want.frame_end) begin
            $display("%0t: frame_end mismatch expected=%b actual=%b", $time,
                     want.frame_end, fe);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   bblur_pkg::csr_reg_type         csr_index;
   logic [bblur_pkg::CsrDataW-1:0] csr_wdata;

   bblur_req_if req_ch ();
   bblur_rsp_if rsp_ch ();

   blur_scoreboard sb;
   bit             quiet;
   int unsigned    send_idle_pct;
   int unsigned    fed_items;
   int unsigned    cycles;

   box_blur_3x3_rgb_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.pixel_out, rsp_ch.frame_end);
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   task automatic send_item(bit op, logic [bblur_pkg::PixelW-1:0] pix);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.pixel_in <= pix;
      do @(posedge clock); while (!req_ch.ready);
      if (sb.note_item(op, pix)) fed_items++;
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // drain all pending results, then give the pipeline time to empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.blurred_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(bblur_pkg::csr_reg_type idx,
                            logic [bblur_pkg::CsrDataW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h);
      settle();
      write_reg(bblur_pkg::RegFrameWidth, bblur_pkg::CsrDataW'(w));
      write_reg(bblur_pkg::RegFrameHeight, bblur_pkg::CsrDataW'(h));
   endtask

   task automatic stream_frame(bit broken);
      int unsigned total;
      int unsigned n;
      total = sb.width * sb.height;
      n = broken ? $urandom_range(1, total) : total;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 3) send_item(1'b1, $urandom());
         send_item(1'b0, $urandom());
      end
      if (!broken) begin
         repeat (sb.width + 1) send_item($urandom_range(0, 3) != 0, $urandom());
      end
   endtask

   function automatic int unsigned pick_size(int unsigned upper);
      case ($urandom_range(0, 5))
         0: return 1;
         1: return 2;
         2: return 3;
         default: return $urandom_range(1, upper);
      endcase
   endfunction

   initial begin
      logic [bblur_pkg::PixelW-1:0] pattern [9];
      int unsigned                  nframes;
      pattern = '{32'hFFFFFFFF, 32'h00000000, 32'hFF000000, 32'h00FF0000, 32'h0000FF00,
                  32'h000000FF, 32'hFFFFFF00, 32'h12345678, 32'hFFFFFFFF};
      sb = new();
      quiet = 1'b0;
      send_idle_pct = 20;
      fed_items = 0;
      cycles = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= 1'b0;
      req_ch.pixel_in <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= bblur_pkg::RegFrameWidth;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(1'b0, $urandom());
      send_item(1'b1, $urandom());
      send_item(1'b0, $urandom());
      send_item(1'b0, $urandom());

      configure(3, 3);
      for (int i = 0; i < 9; i++) begin
         send_item(1'b0, pattern[i]);
         if (i == 3) send_item(1'b1, 32'h0);
      end
      send_item(1'b1, 32'h0);
      send_item(1'b0, 32'hFFFFFFFF);
      send_item(1'b1, 32'h0);
      send_item(1'b1, 32'hFFFFFFFF);

      configure(0, 0);
      send_item(1'b0, 32'hA5A5A5A5);
      send_item(1'b1, 32'h0);
      send_item(1'b0, 32'h0);

      configure(2047, 1);
      repeat (40) send_item(1'b0, $urandom());
      configure(1, 8191);
      repeat (40) send_item(1'b0, $urandom());
      configure(1024, 4096);
      repeat (30) send_item(1'b0, $urandom());

      while (fed_items < 1300) begin
         quiet = fed_items > 1100;
         send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         configure(pick_size(24), pick_size(10));
         nframes = $urandom_range(1, 3);
         for (int unsigned k = 0; k < nframes; k++) begin
            stream_frame(k == nframes - 1 && $urandom_range(0, 5) == 0);
         end
      end

      settle();
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[box_blur_3x3_rgb_top.f]
hdl/bblur_pkg.sv
hdl/bblur_if.sv
hdl/bblur_ram.sv
hdl/bblur_ctrl.sv
hdl/bblur_filter.sv
hdl/box_blur_3x3_rgb_top.sv
dv/box_blur_3x3_rgb_top_tb.sv
